// ===== hw/rtl/ksc_pkg.sv =====
// ----------------------------------------------------------------------------
// ksc_pkg
// Shared types and constants of the keypad scanner: register indexes, field
// widths, the per-key event bundle and the packed result beat.
// ----------------------------------------------------------------------------
package ksc_pkg;

	localparam int KEY_FIELD_W = 8;   // width of key_levels and of every event mask
	localparam int DELAY_W     = 16;  // width of the delay registers
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LONG_DELAY    = 3'd0,
		REG_FIRST_REPEAT  = 3'd1,
		REG_REPEAT_PERIOD = 3'd2,
		REG_LONG_ENABLE   = 3'd3,
		REG_REPEAT_ENABLE = 3'd4
	} cfg_reg_t;

	// Delay settings shared by every key lane.
	typedef struct packed {
		logic [DELAY_W-1:0] long_delay;
		logic [DELAY_W-1:0] first_rpt;
		logic [DELAY_W-1:0] rpt_period;
	} timing_t;

	// Events one key lane raises on one poll.
	typedef struct packed {
		logic press;
		logic rel;
		logic lng;
		logic rpt;
	} lane_ev_t;

	// Result beat, press_events in the lowest bits.
	typedef struct packed {
		logic [KEY_FIELD_W-1:0] repeat_events;
		logic [KEY_FIELD_W-1:0] long_events;
		logic [KEY_FIELD_W-1:0] release_events;
		logic [KEY_FIELD_W-1:0] press_events;
	} result_t;

endpackage

// ===== hw/rtl/ksc_lane.sv =====
// ----------------------------------------------------------------------------
// ksc_lane
// State of one key: held, long-press-done and repeating flags plus two
// saturating poll counters. Events are produced in the cycle of the poll.
// ----------------------------------------------------------------------------
module ksc_lane #(
	parameter int TICK_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              key_down,
	input  logic              long_en,
	input  logic              rpt_en,
	input  ksc_pkg::timing_t  timing,
	output ksc_pkg::lane_ev_t ev
);
	import ksc_pkg::*;

	localparam int CMP_W = (TICK_BITS > DELAY_W) ? TICK_BITS : DELAY_W;

	logic                 held_q;
	logic                 long_done_q;
	logic                 repeating_q;
	logic [TICK_BITS-1:0] long_cnt_q;
	logic [TICK_BITS-1:0] rpt_cnt_q;

	logic                 do_press;
	logic                 do_release;
	logic                 do_hold;
	logic [TICK_BITS-1:0] long_nxt;
	logic [TICK_BITS-1:0] rpt_nxt;
	logic [DELAY_W-1:0]   rpt_lim;
	logic                 long_hit;
	logic                 rpt_hit;

	assign do_press   = step && key_down && !held_q;
	assign do_release = step && !key_down && held_q;
	assign do_hold    = step && key_down && held_q;

	// Counters stick at their maximum value.
	assign long_nxt = (&long_cnt_q) ? long_cnt_q : long_cnt_q + 1'b1;
	assign rpt_nxt  = (&rpt_cnt_q) ? rpt_cnt_q : rpt_cnt_q + 1'b1;
	assign rpt_lim  = repeating_q ? timing.rpt_period : timing.first_rpt;

	assign long_hit = do_hold && !long_done_q && long_en &&
		(CMP_W'(long_nxt) >= CMP_W'(timing.long_delay));
	assign rpt_hit  = do_hold && rpt_en && (CMP_W'(rpt_nxt) >= CMP_W'(rpt_lim));

	assign ev.press = do_press;
	assign ev.rel   = do_release && !long_done_q;
	assign ev.lng   = long_hit;
	assign ev.rpt   = rpt_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			long_done_q <= 1'b0;
			repeating_q <= 1'b0;
			long_cnt_q  <= '0;
			rpt_cnt_q   <= '0;
		end else if (do_press) begin
			held_q      <= 1'b1;
			long_done_q <= 1'b0;
			repeating_q <= 1'b0;
			long_cnt_q  <= '0;
			rpt_cnt_q   <= '0;
		end else if (do_release) begin
			held_q <= 1'b0;
		end else if (do_hold) begin
			long_cnt_q <= long_hit ? '0 : long_nxt;
			rpt_cnt_q  <= rpt_hit ? '0 : rpt_nxt;
			if (long_hit) begin
				long_done_q <= 1'b1;
			end
			if (rpt_hit) begin
				repeating_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ksc_merge.sv =====
// ----------------------------------------------------------------------------
// ksc_merge
// Gathers the lane events into the four masks and holds them in the output
// register until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module ksc_merge #(
	parameter int LANES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ksc_pkg::lane_ev_t ev [LANES],
	input  logic              out_ready,
	output logic              in_ready,
	output logic              out_valid,
	output ksc_pkg::result_t  result
);
	import ksc_pkg::*;

	result_t merged;
	logic    valid_q;
	result_t result_q;

	for (genvar k = 0; k < KEY_FIELD_W; k++) begin : g_bit
		if (k < LANES) begin : g_lane
			assign merged.press_events[k]   = ev[k].press;
			assign merged.release_events[k] = ev[k].rel;
			assign merged.long_events[k]    = ev[k].lng;
			assign merged.repeat_events[k]  = ev[k].rpt;
		end else begin : g_none
			assign merged.press_events[k]   = 1'b0;
			assign merged.release_events[k] = 1'b0;
			assign merged.long_events[k]    = 1'b0;
			assign merged.repeat_events[k]  = 1'b0;
		end
	end

	// A new beat may enter when the stage is empty or when the held one leaves in the same cycle.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_ready) begin
			result_q <= merged;
		end
	end

	assign out_valid = valid_q;
	assign result    = result_q;

endmodule

// ===== hw/rtl/key_press_long_repeat_scanner_core.sv =====
// ----------------------------------------------------------------------------
// key_press_long_repeat_scanner_core
// Keypad scanner with press, release, long-press and auto-repeat events.
// ----------------------------------------------------------------------------
// Each input beat is one poll tick: tdata carries the raw active-low level of
// every key and tuser says whether a receiver is present. For every poll the
// block returns exactly one output beat with four per-key masks: keys just
// pressed, keys released without a long press, keys that reached the long
// press delay and keys that fired an auto-repeat. A poll with tuser low
// leaves all key state alone and returns a beat of zeros. Every key has its
// own lane of logic, so all keys of a poll are updated together; the result
// is registered and appears in the cycle after the poll is accepted, and a new
// poll can be taken every cycle, limited only by the one-deep output
// register, which accepts a beat whenever it is empty or being drained.
// The delay registers count polls, not clock cycles. Write the
// configuration only while no poll is in flight.
// ----------------------------------------------------------------------------
module key_press_long_repeat_scanner_core #(
	parameter int KEY_COUNT = 8,
	parameter int TICK_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Poll input.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] key_levels
	input  logic                              s_axis_tuser,  // [0] app_ready
	// Event output.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] press_events, [15:8] release_events, [23:16] long_events,
	// [31:24] repeat_events
	output logic [31:0]                       m_axis_tdata,
	// Configuration writes.
	input  logic                              cfg_we,
	input  logic [ksc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ksc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import ksc_pkg::*;

	// Only keys that have a bit in key_levels can ever change state.
	localparam int LANES = (KEY_COUNT < KEY_FIELD_W) ? KEY_COUNT : KEY_FIELD_W;

	timing_t                timing_q;
	logic [KEY_FIELD_W-1:0] long_en_q;
	logic [KEY_FIELD_W-1:0] rpt_en_q;

	logic     accept;
	logic     step;
	lane_ev_t lane_ev [LANES];
	result_t  result;

	// Configuration registers. Indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.long_delay <= DELAY_W'(16);
			timing_q.first_rpt  <= DELAY_W'(10);
			timing_q.rpt_period <= DELAY_W'(4);
			long_en_q           <= '0;
			rpt_en_q            <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG_DELAY:    timing_q.long_delay <= cfg_wdata[DELAY_W-1:0];
				REG_FIRST_REPEAT:  timing_q.first_rpt  <= cfg_wdata[DELAY_W-1:0];
				REG_REPEAT_PERIOD: timing_q.rpt_period <= cfg_wdata[DELAY_W-1:0];
				REG_LONG_ENABLE:   long_en_q           <= cfg_wdata[KEY_FIELD_W-1:0];
				REG_REPEAT_ENABLE: rpt_en_q            <= cfg_wdata[KEY_FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	// Key state advances only on an accepted poll that has a receiver.
	assign accept = s_axis_tvalid && s_axis_tready;
	assign step   = accept && s_axis_tuser;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		ksc_lane #(
			.TICK_BITS (TICK_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (step),
			.key_down (!s_axis_tdata[k]),
			.long_en  (long_en_q[k]),
			.rpt_en   (rpt_en_q[k]),
			.timing   (timing_q),
			.ev       (lane_ev[k])
		);
	end

	// The merge stage packs the lane events and holds the result beat.
	ksc_merge #(
		.LANES (LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.ev        (lane_ev),
		.out_ready (m_axis_tready),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.result    (result)
	);

	assign m_axis_tdata = result;

endmodule

// ===== hw/rtl/ksc_checker.sv =====
// ----------------------------------------------------------------------------
// ksc_checker
// Port-level checks of the keypad scanner, bound to the top level.
// ----------------------------------------------------------------------------
module ksc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// A stalled result beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Every accepted poll shows up as a result beat in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted poll produced no result beat");

	// An ignored poll yields an all-zero result.
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> m_axis_tdata == 32'd0)
		else $error("ignored poll produced events");

	// The output stage is never full and blocking while empty.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// A key cannot be pressed and released, nor pressed and long, on one poll.
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[7:0] & m_axis_tdata[15:8]) == 8'd0) &&
			((m_axis_tdata[7:0] & m_axis_tdata[23:16]) == 8'd0))
		else $error("conflicting events for one key");

endmodule

bind key_press_long_repeat_scanner_core ksc_checker u_ksc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_key_press_long_repeat_scanner_core.sv =====
// ----------------------------------------------------------------------------
// tb_key_press_long_repeat_scanner_core
// Self-checking bench for the keypad scanner with long press and auto-repeat.
// ----------------------------------------------------------------------------
// Poll beats go in on the slave side and event beats are drained on the
// master side. Both sides pause at random. A scoreboard class keeps its own
// copy of every key lane and of the delay registers, predicts the four event
// masks for each accepted poll and checks every event beat against them in
// order. The run opens with a short directed sequence. After that come
// random phases, each with its own register setting, in which keys are held
// and released.
// ----------------------------------------------------------------------------
module tb_key_press_long_repeat_scanner_core;

	import ksc_pkg::*;

	// Cycles with no beat on either side before the run is declared hung.
	localparam int QUIET_LIMIT = 2000;
	localparam int NUM_KEYS    = 8;

	// Scoreboard: lane state, delay registers and the queue of event masks
	// still owed by the block.
	class key_event_scoreboard;
		bit [DELAY_W-1:0]     long_dly;
		bit [DELAY_W-1:0]     first_rpt;
		bit [DELAY_W-1:0]     rpt_per;
		bit [NUM_KEYS-1:0]    long_en;
		bit [NUM_KEYS-1:0]    rpt_en;
		bit [NUM_KEYS-1:0]    held;
		bit [NUM_KEYS-1:0]    long_done;
		bit [NUM_KEYS-1:0]    repeating;
		bit [DELAY_W-1:0]     long_cnt[NUM_KEYS];
		bit [DELAY_W-1:0]     rpt_cnt[NUM_KEYS];
		result_t              owed_events[$];
		int                   errors;

		function new();
			long_dly  = 16;
			first_rpt = 10;
			rpt_per   = 4;
			long_en   = '0;
			rpt_en    = '0;
			held      = '0;
			long_done = '0;
			repeating = '0;
			errors    = 0;
			foreach (long_cnt[k]) begin
				long_cnt[k] = '0;
				rpt_cnt[k]  = '0;
			end
		endfunction

		function void set_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
			case (idx)
				REG_LONG_DELAY:    long_dly  = val;
				REG_FIRST_REPEAT:  first_rpt = val;
				REG_REPEAT_PERIOD: rpt_per   = val;
				REG_LONG_ENABLE:   long_en   = val[NUM_KEYS-1:0];
				REG_REPEAT_ENABLE: rpt_en    = val[NUM_KEYS-1:0];
				default: ;
			endcase
		endfunction

		// Advances every key lane by one poll and queues the event masks.
		function void note_poll(bit [KEY_FIELD_W-1:0] levels, bit app_ready);
			result_t          ev;
			bit               down;
			bit [DELAY_W-1:0] lim;
			ev = '0;
			if (app_ready) begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					down = !levels[k];
					if (down && !held[k]) begin
						held[k]      = 1'b1;
						long_done[k] = 1'b0;
						repeating[k] = 1'b0;
						long_cnt[k]  = '0;
						rpt_cnt[k]   = '0;
						ev.press_events[k] = 1'b1;
					end else if (!down && held[k]) begin
						held[k] = 1'b0;
						if (!long_done[k])
							ev.release_events[k] = 1'b1;
					end else if (down && held[k]) begin
						if (long_cnt[k] != '1)
							long_cnt[k]++;
						if (rpt_cnt[k] != '1)
							rpt_cnt[k]++;
						if (!long_done[k] && long_en[k] && long_cnt[k] >= long_dly) begin
							long_cnt[k]  = '0;
							long_done[k] = 1'b1;
							ev.long_events[k] = 1'b1;
						end
						if (rpt_en[k]) begin
							lim = repeating[k] ? rpt_per : first_rpt;
							if (rpt_cnt[k] >= lim) begin
								rpt_cnt[k]   = '0;
								repeating[k] = 1'b1;
								ev.repeat_events[k] = 1'b1;
							end
						end
					end
				end
			end
			owed_events.push_back(ev);
		endfunction

		function void compare_mask(string name, bit [KEY_FIELD_W-1:0] want,
				bit [KEY_FIELD_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (owed_events.size() == 0) begin
				$error("event beat %h arrived with no poll outstanding", got);
				errors++;
			end else begin
				want = owed_events.pop_front();
				compare_mask("press_events", want.press_events, got.press_events);
				compare_mask("release_events", want.release_events, got.release_events);
				compare_mask("long_events", want.long_events, got.long_events);
				compare_mask("repeat_events", want.repeat_events, got.repeat_events);
			end
		endfunction

		function int pending();
			return owed_events.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;   // [7:0] key_levels
	logic                   s_axis_tuser;   // [0] app_ready
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// [7:0] press_events, [15:8] release_events, [23:16] long_events,
	// [31:24] repeat_events
	logic [31:0]            m_axis_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	key_event_scoreboard    key_sb;
	// When set, neither side pauses. Used for burst phases so that
	// back-to-back beats are exercised.
	bit                     steady;
	// Keys the random stimulus currently wants held down.
	bit [NUM_KEYS-1:0]      held_plan;
	int                     quiet_cycles = 0;

	key_press_long_repeat_scanner_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Watchdog: counts cycles in which no beat moves on either side. Every
	// legal pause in this bench is far shorter than the limit.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Pause length in cycles: mostly none or short, now and then long.
	function automatic int pause_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(11, 40);
	endfunction

	// Offers one poll beat and waits for the handshake. The valid line is
	// left high afterwards so that the next call can follow without a gap.
	task automatic send_poll(bit [7:0] levels, bit app_ready);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= levels;
		s_axis_tuser  <= app_ready;
		do @(posedge clk); while (!s_axis_tready);
		key_sb.note_poll(levels, app_ready);
	endtask

	// Drains event beats for the whole run, pausing ready at random.
	task automatic drain_events();
		int gap;
		forever begin
			gap = pause_len();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			key_sb.check_beat(result_t'(m_axis_tdata));
		end
	endtask

	// Stops offering polls and waits until every owed beat has come back,
	// so the registers can be rewritten safely.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (key_sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the enable is dropped afterwards so that
	// consecutive writes never stack two assignments in one step.
	task automatic write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		key_sb.set_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_timing(bit [15:0] ld, bit [15:0] fr, bit [15:0] rp);
		write_reg(REG_LONG_DELAY, ld);
		write_reg(REG_FIRST_REPEAT, fr);
		write_reg(REG_REPEAT_PERIOD, rp);
	endtask

	task automatic write_masks(bit [7:0] long_mask, bit [7:0] rpt_mask);
		write_reg(REG_LONG_ENABLE, {8'h00, long_mask});
		write_reg(REG_REPEAT_ENABLE, {8'h00, rpt_mask});
	endtask

	// Opening sequence: ignored polls, press and release with the reset
	// setting, then a short setting where long press and repeat fire, a
	// release after a long press (which must stay silent) and an ignored
	// poll in the middle of a hold.
	task automatic run_directed();
		send_poll(8'hFF, 1'b1);
		send_poll(8'h00, 1'b0);
		send_poll(8'h00, 1'b1);
		repeat (3) send_poll(8'h00, 1'b1);
		send_poll(8'hFF, 1'b1);
		send_poll(8'h00, 1'b0);
		settle();
		write_timing(16'd3, 16'd2, 16'd1);
		write_masks(8'h0F, 8'h3C);
		send_poll(8'h00, 1'b1);
		repeat (3) send_poll(8'h00, 1'b1);
		send_poll(8'h5A, 1'b0);
		repeat (2) send_poll(8'h00, 1'b1);
		send_poll(8'hF0, 1'b1);
		send_poll(8'hFF, 1'b1);
		send_poll(8'h0F, 1'b1);
		send_poll(8'hFF, 1'b1);
		settle();
	endtask

	// Register setting for one random phase: the first few are the corner
	// settings (shortest, zero, longest, mixed masks), the rest are random
	// and small enough that events fire often.
	task automatic setup_phase(int phase);
		case (phase)
			0: begin
				write_timing(16'd1, 16'd1, 16'd1);
				write_masks(8'hFF, 8'hFF);
			end
			1: begin
				// A zero delay fires its check on every held poll.
				write_timing(16'd0, 16'd0, 16'd0);
				write_masks(8'hFF, 8'hFF);
			end
			2: begin
				write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
				write_masks(8'hFF, 8'hFF);
			end
			3: begin
				write_timing(16'd2, 16'd5, 16'd3);
				write_masks(8'hAA, 8'h55);
			end
			default: begin
				write_timing(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
					16'($urandom_range(0, 6)));
				write_masks(8'($urandom), 8'($urandom));
			end
		endcase
	endtask

	// Random polls: keys stay down or up for runs of polls so that long
	// presses and repeats are reached, with some ignored polls and some
	// polls of pure noise. Only polls with app_ready high are counted.
	task automatic run_random(int count);
		int              done;
		bit [7:0]        levels;
		bit              app_ready;
		done = 0;
		while (done < count) begin
			for (int k = 0; k < NUM_KEYS; k++)
				if ($urandom_range(0, 11) == 0)
					held_plan[k] = ~held_plan[k];
			if ($urandom_range(0, 99) < 8)
				levels = 8'($urandom);
			else
				levels = ~held_plan;
			app_ready = ($urandom_range(0, 9) != 0);
			send_poll(levels, app_ready);
			if (app_ready)
				done++;
		end
	endtask

	initial begin
		key_sb        = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		steady        = 1'b0;
		held_plan     = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fork
			drain_events();
		join_none

		run_directed();

		// Random phases; some of them run as bursts with no pauses at all.
		for (int phase = 0; phase < 8; phase++) begin
			setup_phase(phase);
			steady = ($urandom_range(0, 3) == 0);
			run_random(70);
			settle();
			steady = 1'b0;
		end

		repeat (8) @(posedge clk);
		if (key_sb.errors == 0 && key_sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
